FILE: hdl/keypad_rgb_pwm_dimmer_core_macros.svh
// Assertion macros for the keypad RGB PWM dimmer.
// Expects clk and arst_n in the scope of each use.
`ifndef KEYPAD_RGB_PWM_DIMMER_CORE_MACROS_SVH
`define KEYPAD_RGB_PWM_DIMMER_CORE_MACROS_SVH

// same-cycle implication
`define KPRD_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define KPRD_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: hdl/kprd_pkg.sv
// Shared types, key codes, register indexes and the colour table of the dimmer.
// No dependencies.
`default_nettype none
package kprd_pkg;

	localparam int DUTY_W   = 7;
	localparam int COLOUR_W = 3;
	localparam int DIGIT_W  = 4;
	localparam int KEY_W    = 4;
	localparam int PERIOD_W = 16;
	localparam int STEP_W   = 10;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;
	localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd20;
	localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd1;
	localparam logic [DUTY_W-1:0]   DUTY_MIN     = 7'd1;
	localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd99;
	localparam logic [DUTY_W-1:0]   DUTY_UP_LIM  = 7'd89;
	localparam logic [DUTY_W-1:0]   DUTY_DN_LIM  = 7'd9;
	localparam logic [DUTY_W-1:0]   DUTY_STEP    = 7'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 8'd1;

	localparam logic [KEY_W-1:0] KEY_NUM_COLOURS = 4'd8;
	localparam logic [KEY_W-1:0] KEY_NUM_DIGITS  = 4'd10;
	localparam logic [KEY_W-1:0] KEY_A = 4'd10;
	localparam logic [KEY_W-1:0] KEY_B = 4'd11;
	localparam logic [KEY_W-1:0] KEY_C = 4'd12;
	localparam logic [KEY_W-1:0] KEY_D = 4'd13;
	localparam logic [KEY_W-1:0] KEY_F = 4'd15;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_TENS   = 2'd1,
		MODE_ONES   = 2'd2,
		MODE_COMMIT = 2'd3
	} mode_t;

	// pins {blue, green, red}, active low
	function automatic logic [2:0] pin_pattern(input logic [COLOUR_W-1:0] colour);
		logic [2:0] p;
		case (colour)
			3'd0: p = 3'b110;
			3'd1: p = 3'b101;
			3'd2: p = 3'b011;
			3'd3: p = 3'b010;
			3'd4: p = 3'b100;
			3'd5: p = 3'b001;
			3'd6: p = 3'b000;
			default: p = 3'b111;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/keypad_rgb_pwm_dimmer_core.sv
// Keypad RGB PWM dimmer: an input transaction passes the input register, then
// key/tick logic into the result register, before the result is valid.
// Throughput one item per clock unless m_tready holds a full result register;
// the result register drains while the next item is taken. The path is set by
// the duty*step product and phase compare. arst_n clears all but the data registers:
// colour 0, duty 1, idle, digits 0, dark phase, period 2000 and step 20.
`default_nettype none
`include "keypad_rgb_pwm_dimmer_core_macros.svh"
module keypad_rgb_pwm_dimmer_core
	import kprd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [3:0] key_value, [7:4] zero
	input  wire logic                  s_tuser,  // [0] func
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // [0] red_pin, [1] green_pin, [2] blue_pin,
	                                             // [9:3] duty_now, [12:10] colour_now,
	                                             // [14:13] entry_mode, [18:15] tens_digit,
	                                             // [22:19] ones_digit, [23] zero
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [PERIOD_W-1:0] period_q;
	logic [STEP_W-1:0]   step_q;
	logic [COLOUR_W-1:0] colour_q, colour_d;
	logic [DUTY_W-1:0]   duty_q, duty_d;
	mode_t               mode_q, mode_d;
	logic [DIGIT_W-1:0]  tens_q, tens_d, ones_q, ones_d;

	logic                valid_s1;
	logic                func_s1;
	logic [KEY_W-1:0]    key_s1;
	logic                valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic                advance;
	logic                tick;
	logic                lit_next;
	logic [2:0]          pins;
	logic [DUTY_W-1:0]   entered;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign tick      = advance && func_s1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			step_q   <= STEP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PERIOD) begin
				period_q <= cfg_data;
			end else if (cfg_index == CFG_STEP) begin
				step_q <= cfg_data[STEP_W-1:0];
			end
		end
	end

	always_comb begin
		colour_d = colour_q;
		duty_d   = duty_q;
		mode_d   = mode_q;
		tens_d   = tens_q;
		ones_d   = ones_q;
		entered  = DUTY_W'(tens_q) * DUTY_STEP + DUTY_W'(ones_q);
		if (!func_s1) begin
			if (mode_q == MODE_IDLE && key_s1 < KEY_NUM_COLOURS) begin
				colour_d = key_s1[COLOUR_W-1:0];
			end
			case (key_s1)
				KEY_A: mode_d = MODE_TENS;
				KEY_B: begin
					if (mode_q == MODE_COMMIT) begin
						duty_d = entered;
						mode_d = MODE_IDLE;
					end
				end
				KEY_C: begin
					if (mode_q == MODE_IDLE) begin
						duty_d = (duty_q <= DUTY_DN_LIM) ? DUTY_MIN : duty_q - DUTY_STEP;
					end
				end
				KEY_D: begin
					if (mode_q == MODE_IDLE) begin
						duty_d = (duty_q >= DUTY_UP_LIM) ? DUTY_MAX : duty_q + DUTY_STEP;
					end
				end
				KEY_F: begin
					tens_d = '0;
					ones_d = DIGIT_W'(1);
					duty_d = DUTY_RESET;
				end
				default: ;
			endcase
			if (key_s1 < KEY_NUM_DIGITS) begin
				if (mode_q == MODE_TENS) begin
					tens_d = key_s1;
					mode_d = MODE_ONES;
				end else if (mode_q == MODE_ONES) begin
					ones_d = key_s1;
					mode_d = MODE_COMMIT;
				end
			end
		end
		pins = lit_next ? pin_pattern(colour_d) : 3'b111;
	end

	kprd_pwm u_pwm (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.duty         (duty_q),
		.period_ticks (period_q),
		.step_ticks   (step_q),
		.lit_next     (lit_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= '0;
			duty_q   <= DUTY_RESET;
			mode_q   <= MODE_IDLE;
			tens_q   <= '0;
			ones_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				colour_q <= colour_d;
				duty_q   <= duty_d;
				mode_q   <= mode_d;
				tens_q   <= tens_d;
				ones_q   <= ones_d;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			key_s1  <= s_tdata[KEY_W-1:0];
		end
		if (advance) begin
			data_s2 <= {1'b0, ones_d, tens_d, mode_d, colour_d, duty_d, pins};
		end
	end

	`KPRD_ASSERT_NOW(a_duty_range, 1'b1, duty_q <= DUTY_MAX, "duty above 99")
	`KPRD_ASSERT_NOW(a_digit_range, 1'b1,
		tens_q < KEY_NUM_DIGITS && ones_q < KEY_NUM_DIGITS, "entered digit above 9")
	`KPRD_ASSERT_NEXT(a_colour_hold, mode_q != MODE_IDLE, $stable(colour_q),
		"colour changed outside idle mode")

endmodule
`default_nettype wire

FILE: hdl/kprd_pwm.sv
// PWM phase timer: dark/lit phase alternation driven by timer ticks.
// Depends on kprd_pkg and keypad_rgb_pwm_dimmer_core_macros.svh.
`default_nettype none
`include "keypad_rgb_pwm_dimmer_core_macros.svh"
module kprd_pwm
	import kprd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tick,
	input  wire logic [DUTY_W-1:0]   duty,
	input  wire logic [PERIOD_W-1:0] period_ticks,
	input  wire logic [STEP_W-1:0]   step_ticks,
	output logic                     lit_next
);

	localparam int PROD_W = DUTY_W + STEP_W;

	logic                lit_q;
	logic [PERIOD_W-1:0] ticks_q;
	logic [PERIOD_W-1:0] ticks_d;
	logic [PROD_W-1:0]   prod;
	logic [PERIOD_W-1:0] dark_len;
	logic [PERIOD_W-1:0] lit_len;
	logic [PERIOD_W-1:0] cur_len;
	logic [PERIOD_W-1:0] oth_len;
	logic [PERIOD_W:0]   nxt;

	always_comb begin
		prod = PROD_W'(duty) * PROD_W'(step_ticks);
		if (prod > PROD_W'(period_ticks)) begin
			dark_len = period_ticks;
		end else begin
			dark_len = prod[PERIOD_W-1:0];
		end
		lit_len = period_ticks - dark_len;
		cur_len = lit_q ? lit_len : dark_len;
		oth_len = lit_q ? dark_len : lit_len;
		nxt = {1'b0, ticks_q} + (PERIOD_W+1)'(1);
		lit_next = lit_q;
		ticks_d = ticks_q;
		if (tick) begin
			if (nxt >= {1'b0, cur_len}) begin
				ticks_d = '0;
				if (oth_len != '0) begin
					lit_next = ~lit_q;
				end else if (cur_len == '0) begin
					lit_next = 1'b0;
				end
			end else begin
				ticks_d = nxt[PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q   <= 1'b0;
			ticks_q <= '0;
		end else begin
			lit_q   <= lit_next;
			ticks_q <= ticks_d;
		end
	end

	`KPRD_ASSERT_NEXT(a_zero_period, tick && period_ticks == '0,
		!lit_q && ticks_q == '0, "zero period must park in dark phase")
	`KPRD_ASSERT_NEXT(a_count_step, tick,
		ticks_q == '0 || ticks_q == ($past(ticks_q) + PERIOD_W'(1)),
		"phase counter must count by one or restart")
	`KPRD_ASSERT_NEXT(a_hold_no_tick, !tick, $stable(ticks_q) && $stable(lit_q),
		"phase state moved without a tick")

endmodule
`default_nettype wire
